FILE: rtl/core/sma_pkg.sv
// ============================================================================
// sma_pkg
// Shared types and constants for the stack machine ALU: command codes,
// status codes, sequencer states, port field widths and default sizes.
// ============================================================================
`default_nettype none

package sma_pkg;

    // Default sizes handed to the top level
    localparam int SMA_STACK_DEPTH = 64;
    localparam int SMA_DATA_WIDTH  = 32;

    // Fixed port field widths
    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // Command codes (codes above CMD_POP are no-ops)
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 4'd0,
        CMD_ADD     = 4'd1,
        CMD_SUB     = 4'd2,
        CMD_MUL     = 4'd3,
        CMD_DIV     = 4'd4,
        CMD_MOD     = 4'd5,
        CMD_NOT     = 4'd6,
        CMD_GREATER = 4'd7,
        CMD_DUP     = 4'd8,
        CMD_SWAP    = 4'd9,
        CMD_DROP    = 4'd10,
        CMD_POP     = 4'd11
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MAGA,
        S_MAGB,
        S_ITER,
        S_FIX,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/sma_ram.sv
// ============================================================================
// sma_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stack_machine_alu.sv
// ============================================================================
// stack_machine_alu
// Operand stack with push, arithmetic, compare and stack shuffling commands,
// built around one shared adder driven by a small sequencer.
// ============================================================================
//
//  Channel  | Direction | Handshake           | Beat contents
//  ---------+-----------+---------------------+-------------------------------
//  cmd      | in        | cmd_valid/cmd_stall | cmd, value
//  res      | out       | res_valid/res_stall | top_value, depth, status
//
//  Sequencing: push, not, dup and rejected commands finish from the decode
//  state; add, sub, greater, swap, drop and pop take one RAM read of the entry
//  below the top. mul, and div/mod unless the divisor is zero, run the shift-add
//  / restoring loop through the shared adder (one bit a cycle).
//  The top entry lives in a register; the RAM holds every entry.
//  Reset clears the entry count and the sequencer; the RAM is not cleared.
//  A result waiting under res_stall holds the sequencer in its final state.
//
`default_nettype none

module stack_machine_alu
    import sma_pkg::*;
#(
    parameter int STACK_DEPTH = SMA_STACK_DEPTH,
    parameter int DATA_WIDTH  = SMA_DATA_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [VALUE_W-1:0]       top_value,
    output logic [DEPTH_W-1:0]       depth,
    output logic [STATUS_W-1:0]      status
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(DW);

    // Control registers
    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              res_valid_reg, res_valid_next;

    // Payload registers
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [DW-1:0]       top_reg, top_next;
    logic [DW-1:0]       a_reg, a_next;
    logic [DW-1:0]       b_reg, b_next;
    logic [DW-1:0]       q_reg, q_next;
    logic [DW-1:0]       acc_reg, acc_next;
    logic [DW-1:0]       pop_reg, pop_next;
    logic                sa_reg, sa_next;
    logic [IW-1:0]       iter_reg, iter_next;
    status_t             op_status_reg, op_status_next;
    logic [VALUE_W-1:0]  top_value_reg, top_value_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // RAM port
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DW-1:0]     wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DW-1:0]     rd_data;

    // Shared adder
    logic [DW:0]       alu_x, alu_y, alu_sum;
    logic              alu_ci;

    // Derived values
    logic [CW-1:0]        cnt_m1, cnt_m2;
    logic                 full, dec_under, dec_over, dec_nop, dec_reject, dec_single;
    logic                 need_one, need_two, res_free, top_zero, gt_bit;
    logic [DW+VALUE_W-1:0] push_ext;
    logic [DW-1:0]        push_val;
    logic [DW-1:0]        rep_val, fix_val;
    logic                 fix_neg;
    logic [DW+VALUE_W-1:0] rep_ext;
    logic [CW+DEPTH_W-1:0] depth_ext;
    logic [DW:0]          a_sx, b_sx, div_trial;

    sma_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Address arithmetic and decode checks
    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_m2   = cnt_reg - CW'(2);
    assign rd_addr  = cnt_m2[AW-1:0];
    assign full     = (cnt_reg == CW'(STACK_DEPTH));
    assign top_zero = (top_reg == '0);
    assign res_free = !res_valid_reg || !res_stall;

    assign need_one = (cmd_reg == CMD_NOT) || (cmd_reg == CMD_DUP) ||
                      (cmd_reg == CMD_DROP) || (cmd_reg == CMD_POP);
    assign need_two = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB) ||
                      (cmd_reg == CMD_MUL) || (cmd_reg == CMD_DIV) ||
                      (cmd_reg == CMD_MOD) || (cmd_reg == CMD_GREATER) ||
                      (cmd_reg == CMD_SWAP);
    assign dec_under  = (need_one && (cnt_reg == '0)) || (need_two && (cnt_reg < CW'(2)));
    assign dec_over   = ((cmd_reg == CMD_PUSH) || (cmd_reg == CMD_DUP)) && full;
    assign dec_nop    = (cmd_reg > CMD_POP);
    assign dec_reject = dec_under || dec_over || dec_nop;
    assign dec_single = (cmd_reg == CMD_PUSH) || (cmd_reg == CMD_NOT) ||
                        (cmd_reg == CMD_DUP);

    // Push value: sign-extend from the port width, keep the data width
    assign push_ext = {{DW{val_reg[VALUE_W-1]}}, val_reg};
    assign push_val = push_ext[DW-1:0];

    // Operands sign-extended one bit for the shared adder
    assign a_sx = {top_reg[DW-1], top_reg};
    assign b_sx = {rd_data[DW-1], rd_data};
    assign div_trial = {acc_reg, q_reg[DW-1]};

    // Shared adder
    assign alu_sum = alu_x + alu_y + (DW+1)'(alu_ci);
    assign gt_bit  = !alu_sum[DW] && (alu_sum != '0);

    // Final sign fix selection
    always_comb
    begin
        case (cmd_reg)
            CMD_DIV:
            begin
                fix_val = q_reg;
                fix_neg = sa_reg ^ b_reg[DW-1];
            end
            CMD_MOD:
            begin
                fix_val = acc_reg;
                fix_neg = b_reg[DW-1];
            end
            default:
            begin
                fix_val = acc_reg;
                fix_neg = 1'b0;
            end
        endcase
    end

    // Reported value: popped entry for pop, else current top or zero
    assign rep_val = ((cmd_reg == CMD_POP) && (op_status_reg == ST_OK)) ? pop_reg :
                     ((cnt_reg != '0) ? top_reg : '0);
    assign rep_ext   = {{VALUE_W{rep_val[DW-1]}}, rep_val};
    assign depth_ext = {{DEPTH_W{1'b0}}, cnt_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (dec_reject || dec_single)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                case (cmd_reg)
                    CMD_MUL:
                    begin
                        state_next = S_ITER;
                    end
                    CMD_DIV, CMD_MOD:
                    begin
                        state_next = top_zero ? S_WRITE : S_MAGA;
                    end
                    CMD_DROP, CMD_POP:
                    begin
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_WRITE;
                    end
                endcase
            end
            S_MAGA:
            begin
                state_next = S_MAGB;
            end
            S_MAGB:
            begin
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (iter_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM port and shared adder control
    always_comb
    begin
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        top_next       = top_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        pop_next       = pop_reg;
        sa_next        = sa_reg;
        iter_next      = iter_reg;
        op_status_next = op_status_reg;
        top_value_next = top_value_reg;
        depth_next     = depth_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg && res_stall;
        wr_en          = 1'b0;
        wr_addr        = cnt_m1[AW-1:0];
        wr_data        = top_reg;
        alu_x          = '0;
        alu_y          = '0;
        alu_ci         = 1'b0;

        case (state_reg)
            // Capture the command beat
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    val_next = value;
                end
            end
            // Check stack bounds, finish single-entry commands
            S_DECODE:
            begin
                if (dec_under)
                begin
                    op_status_next = ST_UNDER;
                end
                else if (dec_over)
                begin
                    op_status_next = ST_OVER;
                end
                else
                begin
                    op_status_next = ST_OK;
                    case (cmd_reg)
                        CMD_PUSH:
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = cnt_reg[AW-1:0];
                            wr_data  = push_val;
                            top_next = push_val;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        CMD_DUP:
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = cnt_reg[AW-1:0];
                            cnt_next = cnt_reg + CW'(1);
                        end
                        CMD_NOT:
                        begin
                            wr_en    = 1'b1;
                            wr_data  = {{(DW-1){1'b0}}, top_zero};
                            top_next = {{(DW-1){1'b0}}, top_zero};
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            // Second entry arrives from the RAM
            S_READ:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        alu_x    = b_sx;
                        alu_y    = a_sx;
                        top_next = alu_sum[DW-1:0];
                        cnt_next = cnt_m1;
                    end
                    CMD_SUB:
                    begin
                        alu_x    = b_sx;
                        alu_y    = ~a_sx;
                        alu_ci   = 1'b1;
                        top_next = alu_sum[DW-1:0];
                        cnt_next = cnt_m1;
                    end
                    CMD_GREATER:
                    begin
                        alu_x    = b_sx;
                        alu_y    = ~a_sx;
                        alu_ci   = 1'b1;
                        top_next = {{(DW-1){1'b0}}, gt_bit};
                        cnt_next = cnt_m1;
                    end
                    CMD_MUL:
                    begin
                        b_next    = rd_data;
                        q_next    = top_reg;
                        acc_next  = '0;
                        iter_next = IW'(DW - 1);
                    end
                    CMD_DIV, CMD_MOD:
                    begin
                        if (top_zero)
                        begin
                            top_next       = '0;
                            op_status_next = ST_DIVZ;
                            cnt_next       = cnt_m1;
                        end
                        else
                        begin
                            b_next = rd_data;
                            a_next = top_reg;
                        end
                    end
                    CMD_SWAP:
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_m2[AW-1:0];
                        top_next = rd_data;
                    end
                    default:
                    begin
                        // drop and pop
                        pop_next = top_reg;
                        top_next = rd_data;
                        cnt_next = cnt_m1;
                    end
                endcase
            end
            // Divisor magnitude
            S_MAGA:
            begin
                sa_next = a_reg[DW-1];
                alu_x   = a_reg[DW-1] ? '0 : {1'b0, a_reg};
                alu_y   = a_reg[DW-1] ? ~{1'b0, a_reg} : '0;
                alu_ci  = a_reg[DW-1];
                a_next  = alu_sum[DW-1:0];
            end
            // Dividend magnitude, start the loop
            S_MAGB:
            begin
                alu_x     = b_reg[DW-1] ? '0 : {1'b0, b_reg};
                alu_y     = b_reg[DW-1] ? ~{1'b0, b_reg} : '0;
                alu_ci    = b_reg[DW-1];
                q_next    = alu_sum[DW-1:0];
                acc_next  = '0;
                iter_next = IW'(DW - 1);
            end
            // One bit of shift-add multiply or restoring divide
            S_ITER:
            begin
                iter_next = iter_reg - IW'(1);
                q_next    = {q_reg[DW-2:0], 1'b0};
                if (cmd_reg == CMD_MUL)
                begin
                    alu_x    = {1'b0, acc_reg[DW-2:0], 1'b0};
                    alu_y    = q_reg[DW-1] ? {1'b0, b_reg} : '0;
                    acc_next = alu_sum[DW-1:0];
                end
                else
                begin
                    alu_x     = div_trial;
                    alu_y     = ~{1'b0, a_reg};
                    alu_ci    = 1'b1;
                    q_next[0] = !alu_sum[DW];
                    acc_next  = alu_sum[DW] ? div_trial[DW-1:0] : alu_sum[DW-1:0];
                end
            end
            // Apply result sign, drop one entry
            S_FIX:
            begin
                alu_x    = fix_neg ? '0 : {1'b0, fix_val};
                alu_y    = fix_neg ? ~{1'b0, fix_val} : '0;
                alu_ci   = fix_neg;
                top_next = alu_sum[DW-1:0];
                cnt_next = cnt_m1;
            end
            // Write the new top back to the RAM
            S_WRITE:
            begin
                wr_en = 1'b1;
            end
            // Load the result register once it is free
            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    top_value_next = rep_ext[VALUE_W-1:0];
                    depth_next     = depth_ext[DEPTH_W-1:0];
                    status_next    = op_status_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        top_reg       <= top_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        q_reg         <= q_next;
        acc_reg       <= acc_next;
        pop_reg       <= pop_next;
        sa_reg        <= sa_next;
        iter_reg      <= iter_next;
        op_status_reg <= op_status_next;
        top_value_reg <= top_value_next;
        depth_reg     <= depth_next;
        status_reg    <= status_next;
    end

    // Ports
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign top_value = top_value_reg;
    assign depth     = depth_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    // Entry count never passes the stack depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    // Overflow is only reported with a full stack in the same beat
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status == ST_OVER)) |-> (depth == DEPTH_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    // Underflow is only reported with fewer than two entries in the same beat
    a_under_low: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status == ST_UNDER)) |-> (depth < DEPTH_W'(2)))
        else $error("underflow reported with two or more entries");

    // Entry count moves only in states that push or pop
    a_cnt_states: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (($past(state_reg) == S_DECODE) || ($past(state_reg) == S_READ) ||
             ($past(state_reg) == S_FIX)))
        else $error("entry count changed outside a push or pop state");
`endif

endmodule

`default_nettype wire

FILE: sim/stack_machine_alu_tb.sv
// ============================================================================
// stack_machine_alu_tb
// Self-checking bench for the operand stack. A queue of commands feeds a
// clocked driver. A clocked monitor predicts each accepted command on its own
// copy of the stack and compares every result beat field by field. Both
// channels idle and stall at random, except for one quiet stretch.
// ============================================================================
`timescale 1ns / 1ps

module stack_machine_alu_tb;
    import sma_pkg::*;

    localparam int STACK_MAX      = SMA_STACK_DEPTH;
    localparam int RANDOM_ITEMS   = 850;
    localparam int IDLE_PCT       = 20;
    localparam int QUIET_FROM     = 5000;
    localparam int QUIET_TO       = 8000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] val;
    } stack_cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  top;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } stack_result_t;

    // Clock, reset and block ports
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    cmd       = '0;
    logic [VALUE_W-1:0]  value     = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [VALUE_W-1:0]  top_value;
    logic [DEPTH_W-1:0]  depth;
    logic [STATUS_W-1:0] status;

    // Bench state
    stack_cmd_t    cmd_backlog[$];
    stack_result_t awaited_results[$];
    logic [VALUE_W-1:0] shadow_stack[STACK_MAX];
    int  shadow_count   = 0;
    logic cmd_taken     = 1'b0;
    int  cycle_count    = 0;
    int  silent_cycles  = 0;
    int  error_count    = 0;
    int  cmds_accepted  = 0;
    int  results_seen   = 0;
    int  under_seen     = 0;
    int  over_seen      = 0;
    int  divz_seen      = 0;
    bit  quiet;

    stack_machine_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .top_value (top_value),
        .depth     (depth),
        .status    (status)
    );

    always #10 clk = ~clk;

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    // Apply one command to the shadow stack and return the result it reports
    function automatic stack_result_t stack_apply(logic [CMD_W-1:0] op,
                                                  logic [VALUE_W-1:0] v);
        stack_result_t res;
        logic [VALUE_W-1:0] a, b, q, ma, mb;
        logic [STATUS_W-1:0] st;
        bit popped;
        int need;
        st     = ST_OK;
        q      = '0;
        popped = 1'b0;
        case (op)
            CMD_NOT, CMD_DUP, CMD_DROP, CMD_POP: need = 1;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_GREATER, CMD_SWAP: need = 2;
            default: need = 0;
        endcase

        if (shadow_count < need) begin
            st = ST_UNDER;
        end
        else if ((op == CMD_PUSH || op == CMD_DUP) && shadow_count >= STACK_MAX) begin
            st = ST_OVER;
        end
        else begin
            case (op)
                CMD_PUSH:
                begin
                    shadow_stack[shadow_count] = v;
                    shadow_count++;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_GREATER:
                begin
                    a = shadow_stack[shadow_count-1];
                    b = shadow_stack[shadow_count-2];
                    if (op == CMD_ADD)
                        q = b + a;
                    else if (op == CMD_SUB)
                        q = b - a;
                    else if (op == CMD_MUL)
                        q = b * a;
                    else if (op == CMD_GREATER)
                        q = ($signed(b) > $signed(a)) ? 32'd1 : 32'd0;
                    else if (a == '0) begin
                        q  = '0;
                        st = ST_DIVZ;
                    end
                    else begin
                        // truncate toward zero on magnitudes, then fix the sign
                        ma = a[VALUE_W-1] ? -a : a;
                        mb = b[VALUE_W-1] ? -b : b;
                        if (op == CMD_DIV) begin
                            q = mb / ma;
                            if (a[VALUE_W-1] != b[VALUE_W-1])
                                q = -q;
                        end
                        else begin
                            q = mb % ma;
                            if (b[VALUE_W-1])
                                q = -q;
                        end
                    end
                    shadow_count--;
                    shadow_stack[shadow_count-1] = q;
                end
                CMD_NOT:
                    shadow_stack[shadow_count-1] =
                        (shadow_stack[shadow_count-1] == '0) ? 32'd1 : 32'd0;
                CMD_DUP:
                begin
                    shadow_stack[shadow_count] = shadow_stack[shadow_count-1];
                    shadow_count++;
                end
                CMD_SWAP:
                begin
                    a = shadow_stack[shadow_count-1];
                    shadow_stack[shadow_count-1] = shadow_stack[shadow_count-2];
                    shadow_stack[shadow_count-2] = a;
                end
                CMD_DROP:
                    shadow_count--;
                CMD_POP:
                begin
                    shadow_count--;
                    q      = shadow_stack[shadow_count];
                    popped = 1'b1;
                end
                default: ;
            endcase
        end

        if (popped)
            res.top = q;
        else
            res.top = (shadow_count == 0) ? '0 : shadow_stack[shadow_count-1];
        res.depth  = DEPTH_W'(shadow_count);
        res.status = st;
        return res;
    endfunction

    // Operand values weighted toward the corners
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return VAL_MIN;
            4: return VAL_MAX;
            5, 6: return VALUE_W'($signed($urandom_range(20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] v);
        stack_cmd_t c;
        c.op  = op;
        c.val = v;
        cmd_backlog.push_back(c);
    endtask

    // Pick one of add, sub, mul, div, mod, not, greater
    function automatic logic [CMD_W-1:0] CMD_WIDTH_ARITH();
        return CMD_W'(CMD_ADD + $urandom_range(6));
    endfunction

    // Drive: present a new beat once the last one is taken, or idle
    always @(negedge clk) begin
        stack_cmd_t next_cmd;
        if (!rst_n) begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_taken) begin
            if (cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                next_cmd  = cmd_backlog.pop_front();
                cmd_valid <= 1'b1;
                cmd       <= next_cmd.op;
                value     <= next_cmd.val;
            end
            else begin
                cmd_valid <= 1'b0;
            end
        end
        res_stall <= rst_n && !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: check result beats, then predict newly accepted commands
    always @(posedge clk) begin
        stack_result_t want;
        bit cmd_fire, res_fire;
        cmd_fire = rst_n && cmd_valid && !cmd_stall;
        res_fire = rst_n && res_valid && !res_stall;
        cmd_taken <= cmd_fire;
        if (rst_n)
            cycle_count <= cycle_count + 1;
        silent_cycles <= (cmd_fire || res_fire) ? 0 : silent_cycles + 1;

        if (res_fire) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result beat: top=%h depth=%0d status=%0d",
                         $realtime, top_value, depth, status);
                error_count++;
            end
            else begin
                want = awaited_results.pop_front();
                if (top_value !== want.top) begin
                    $display("%0t: top_value mismatch: expected %h, actual %h",
                             $realtime, want.top, top_value);
                    error_count++;
                end
                if (depth !== want.depth) begin
                    $display("%0t: depth mismatch: expected %0d, actual %0d",
                             $realtime, want.depth, depth);
                    error_count++;
                end
                if (status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, want.status, status);
                    error_count++;
                end
            end
        end

        if (cmd_fire) begin
            cmds_accepted++;
            want = stack_apply(cmd, value);
            case (want.status)
                ST_UNDER: under_seen++;
                ST_OVER:  over_seen++;
                ST_DIVZ:  divz_seen++;
                default: ;
            endcase
            awaited_results.push_back(want);
        end
    end

    // Watchdog: end the run if no beat moves for too long
    initial begin
        wait (rst_n);
        while (silent_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no beat accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("** stack_machine_alu: FAILED **");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int kind, len, r, rand_count;

        // Directed: underflow on empty, spare code, wraps and divide corners
        add_cmd(CMD_POP, '0);
        add_cmd(CMD_ADD, '0);
        add_cmd(CMD_NOT, '0);
        add_cmd(CMD_SWAP, '0);
        add_cmd(CMD_POP + 4'd4, '1);
        add_cmd(CMD_PUSH, VAL_MAX);
        add_cmd(CMD_PUSH, 32'd1);
        add_cmd(CMD_ADD, '0);
        add_cmd(CMD_PUSH, '1);
        add_cmd(CMD_DIV, '0);
        add_cmd(CMD_PUSH, '1);
        add_cmd(CMD_MOD, '0);
        add_cmd(CMD_PUSH, 32'd5);
        add_cmd(CMD_PUSH, '0);
        add_cmd(CMD_DIV, '0);
        add_cmd(CMD_NOT, '0);
        add_cmd(CMD_PUSH, -32'sd7);
        add_cmd(CMD_PUSH, 32'd2);
        add_cmd(CMD_MOD, '0);
        add_cmd(CMD_SUB, '0);
        add_cmd(CMD_PUSH, -32'sd2);
        add_cmd(CMD_MUL, '0);
        add_cmd(CMD_DUP, '0);
        add_cmd(CMD_GREATER, '0);
        add_cmd(CMD_SWAP, '0);
        add_cmd(CMD_DROP, '0);
        add_cmd(CMD_POP, '0);

        // Random bursts: fill to overflow, drain to underflow, or mixed work
        rand_count = 0;
        while (rand_count < RANDOM_ITEMS) begin
            kind = $urandom_range(9);
            if (kind < 2) begin
                len = $urandom_range(72, 66);
                repeat (len)
                    add_cmd(($urandom_range(99) < 85) ? CMD_PUSH : CMD_DUP, pick_value());
            end
            else if (kind == 2) begin
                len = $urandom_range(72, 66);
                repeat (len) begin
                    r = $urandom_range(99);
                    if (r < 40)
                        add_cmd(CMD_POP, $urandom);
                    else if (r < 60)
                        add_cmd(CMD_DROP, $urandom);
                    else if (r < 90)
                        add_cmd(CMD_WIDTH_ARITH(), $urandom);
                    else
                        add_cmd(CMD_NOT, $urandom);
                end
            end
            else begin
                len = $urandom_range(60, 20);
                repeat (len) begin
                    r = $urandom_range(99);
                    if (r < 32)
                        add_cmd(CMD_PUSH, pick_value());
                    else if (r < 67)
                        add_cmd(CMD_WIDTH_ARITH(), $urandom);
                    else if (r < 74)
                        add_cmd(CMD_DUP, $urandom);
                    else if (r < 81)
                        add_cmd(CMD_SWAP, $urandom);
                    else if (r < 87)
                        add_cmd(CMD_DROP, $urandom);
                    else if (r < 95)
                        add_cmd(CMD_POP, $urandom);
                    else
                        add_cmd(CMD_POP + 4'd1 + CMD_W'($urandom_range(3)), $urandom);
                end
            end
            rand_count += len;
        end

        // Hold reset, then release away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog and every awaited result, then let the block settle
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d commands and %0d result beats over %0d cycles.",
                 cmds_accepted, results_seen, cycle_count);
        $display("Underflows %0d, overflows %0d, divides by zero %0d, errors %0d.",
                 under_seen, over_seen, divz_seen, error_count);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("** stack_machine_alu: PASSED **");
        else
            $display("** stack_machine_alu: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sma_pkg.sv
rtl/core/sma_ram.sv
rtl/core/stack_machine_alu.sv
sim/stack_machine_alu_tb.sv
